[hw/rtl/qdr_pkg.sv]
package qdr_pkg;

    // Default position counter width.
    localparam int QDR_COUNT_WIDTH = 32;

    // Fixed field widths.
    localparam int TIME_W = 32;
    localparam int REG_W  = 16;
    localparam int OUT_W  = 32;

    // Elapsed time times counts per revolution.
    localparam int TDT_W = TIME_W + REG_W;

    // Full rpm divisor: elapsed time times counts per revolution times denominator.
    localparam int DIV_DEN_W = TIME_W + 2 * REG_W;

    // Multiplier operand B width.
    localparam int MUL_B_W = 32;

    // Scale factors for counts per second and rpm.
    localparam int MS_PER_S    = 1000;
    localparam int SEC_PER_MIN = 60;
    localparam int RPM_SCALE   = MS_PER_S * SEC_PER_MIN;

    // Channel codes, A in bit 1 and B in bit 0.
    localparam logic [1:0] GRAY_00 = 2'b00;
    localparam logic [1:0] GRAY_01 = 2'b01;
    localparam logic [1:0] GRAY_10 = 2'b10;
    localparam logic [1:0] GRAY_11 = 2'b11;

    // Operation codes of an input beat.
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_INVERT    = 2'd0,
        REG_CPR       = 2'd1,
        REG_RATIO_NUM = 2'd2,
        REG_RATIO_DEN = 2'd3
    } reg_index_t;

    // Status of a shared arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Next code in the counting-up direction.
    function automatic logic [1:0] gray_up(input logic [1:0] cur);
        logic [1:0] nxt;
        case (cur)
            GRAY_00: nxt = GRAY_10;
            GRAY_10: nxt = GRAY_11;
            GRAY_11: nxt = GRAY_01;
            default: nxt = GRAY_00;
        endcase
        return nxt;
    endfunction

    // Next code in the counting-down direction.
    function automatic logic [1:0] gray_down(input logic [1:0] cur);
        logic [1:0] nxt;
        case (cur)
            GRAY_00: nxt = GRAY_01;
            GRAY_10: nxt = GRAY_00;
            GRAY_11: nxt = GRAY_10;
            default: nxt = GRAY_11;
        endcase
        return nxt;
    endfunction

    // Apply a sign to a magnitude and saturate to signed 32 bits.
    // The flag big means the magnitude is at least 2^31.
    function automatic logic [OUT_W-1:0] sat_s32(
        input logic                neg,
        input logic                big,
        input logic [OUT_W-2:0]    mag
    );
        logic [OUT_W-1:0] res;
        if (neg) begin
            res = big ? {1'b1, {(OUT_W-1){1'b0}}} : (~{1'b0, mag} + OUT_W'(1));
        end
        else begin
            res = big ? {1'b0, {(OUT_W-1){1'b1}}} : {1'b0, mag};
        end
        return res;
    endfunction

endpackage

[hw/rtl/quadrature_decoder_rpm_top.sv]
// Channel-sample beats, and measure beats whose time has not advanced, give their result in
// the cycle after acceptance; the next beat is then taken at once unless the output stalls.
// A measure beat that takes a snapshot runs three serial multiplies and two restoring divides
// on the shared units; no beat is accepted meanwhile.
// Asynchronous active-low reset clears all counters and rate results and restores the registers.
module quadrature_decoder_rpm_top
    import qdr_pkg::*;
#(
    parameter int COUNT_WIDTH = QDR_COUNT_WIDTH
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [REG_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic                    chan_a,
    input  logic                    chan_b,
    input  logic [TIME_W-1:0]       now_ms,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] position_count,
    output logic [OUT_W-1:0]        skipped_total,
    output logic [1:0]              channel_bits,
    output logic signed [OUT_W-1:0] counts_per_second,
    output logic signed [OUT_W-1:0] shaft_rpm,
    output logic                    measured
);

    localparam int CW      = COUNT_WIDTH;
    localparam int POS_W   = (CW > OUT_W) ? CW : OUT_W;
    localparam int MUL_A_W = (CW > TDT_W) ? CW : TDT_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = CW + MUL_B_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FREQ,
        ST_DIV_FREQ,
        ST_MUL_RPMN,
        ST_MUL_RPMD,
        ST_DIV_RPM,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic             invert_reg;
    logic [REG_W-1:0] cpr_reg;
    logic [REG_W-1:0] ratio_num_reg;
    logic [REG_W-1:0] ratio_den_reg;

    // Decoder and measurement state.
    logic [1:0]        chan_reg;
    logic              known_reg;
    logic [CW-1:0]     pos_reg;
    logic [OUT_W-1:0]  skip_reg;
    logic [TIME_W-1:0] last_ms_reg;
    logic [OUT_W-1:0]  freq_reg;
    logic [OUT_W-1:0]  rpm_reg;

    logic [1:0]       chan_next;
    logic             known_next;
    logic [CW-1:0]    pos_next;
    logic [OUT_W-1:0] skip_next;

    // Sequencer outputs and working registers.
    logic              mul_start_reg;
    logic              div_start_reg;
    logic [CW-1:0]     mag_reg;
    logic              neg_reg;
    logic [TIME_W-1:0] dt_reg;
    logic [TDT_W-1:0]  t_reg;
    logic [OUT_W-1:0]  k_reg;
    logic [NUM_W-1:0]  nnum_reg;

    // Output register.
    logic             out_valid_reg;
    logic [OUT_W-1:0] position_count_reg;
    logic [OUT_W-1:0] skipped_total_reg;
    logic [1:0]       channel_bits_reg;
    logic [OUT_W-1:0] counts_per_second_reg;
    logic [OUT_W-1:0] shaft_rpm_reg;
    logic             measured_reg;

    logic [1:0]         chan_in;
    logic [TIME_W-1:0]  dt_now;
    logic               advance;
    logic               out_free;
    logic               accept;
    logic               take_sample;
    logic               start_meas;
    logic               quick_load;
    logic               finish_load;
    logic               load_out;
    logic [CW-1:0]      snap;
    logic               snap_neg;
    logic [CW-1:0]      snap_mag;
    logic [POS_W-1:0]   pos_wide;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_product;
    unit_stat_t         mul_stat;
    logic [NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [NUM_W-1:0]   div_q;
    unit_stat_t         div_stat;
    logic               q_big;
    logic               den_zero;

    // Shared serial multiplier.
    qdr_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product),
        .stat    (mul_stat)
    );

    // Shared restoring divider.
    qdr_div #(
        .N_W (NUM_W),
        .D_W (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .num      (div_num),
        .den      (div_den),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Handshake decisions.
    always_comb
    begin
        out_free    = !out_valid_reg || !out_stall;
        in_stall    = !((state_reg == ST_IDLE) && out_free);
        accept      = in_valid && !in_stall;
        dt_now      = now_ms - last_ms_reg;
        advance     = (now_ms > last_ms_reg);
        take_sample = accept && (op == OP_SAMPLE);
        start_meas  = accept && (op == OP_MEASURE) && advance;
        quick_load  = accept && !start_meas;
        finish_load = (state_reg == ST_FINISH) && out_free;
        load_out    = quick_load || finish_load;
    end

    // Channel decoding for a sample beat.
    always_comb
    begin
        chan_in    = {chan_a, chan_b};
        chan_next  = chan_reg;
        known_next = known_reg;
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        if (take_sample)
        begin
            if (!known_reg)
            begin
                chan_next  = chan_in;
                known_next = 1'b1;
            end
            else if (chan_in != chan_reg)
            begin
                if (chan_in == gray_up(chan_reg))
                begin
                    pos_next = pos_reg + CW'(1);
                end
                else if (chan_in == gray_down(chan_reg))
                begin
                    pos_next = pos_reg - CW'(1);
                end
                else
                begin
                    skip_next = skip_reg + OUT_W'(1);
                end
                chan_next = chan_in;
            end
        end
        pos_wide = POS_W'(pos_next);
    end

    // Snapshot sign and magnitude; the most negative count keeps its sign.
    always_comb
    begin
        snap     = invert_reg ? (~pos_reg + CW'(1)) : pos_reg;
        snap_neg = snap[CW-1];
        snap_mag = snap_neg ? (~snap + CW'(1)) : snap;
    end

    // Operand selection for the shared units, by sequencer step.
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        case (state_reg)
            ST_MUL_FREQ:
            begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(MS_PER_S);
            end
            ST_MUL_RPMN:
            begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = k_reg;
            end
            ST_MUL_RPMD:
            begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(ratio_den_reg);
            end
            ST_DIV_FREQ:
            begin
                div_num = mul_product[NUM_W-1:0];
                div_den = DIV_DEN_W'(dt_reg);
            end
            ST_DIV_RPM:
            begin
                div_num = nnum_reg;
                div_den = mul_product[DIV_DEN_W-1:0];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        q_big    = |div_q[NUM_W-1:OUT_W-1];
        den_zero = (cpr_reg == '0) || (ratio_den_reg == '0);
    end

    // Sequencer, configuration and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            invert_reg    <= 1'b0;
            cpr_reg       <= REG_W'(1);
            ratio_num_reg <= REG_W'(1);
            ratio_den_reg <= REG_W'(1);
            chan_reg      <= GRAY_00;
            known_reg     <= 1'b0;
            pos_reg       <= '0;
            skip_reg      <= '0;
            last_ms_reg   <= '0;
            freq_reg      <= '0;
            rpm_reg       <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;

            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_INVERT:    invert_reg    <= cfg_wdata[0];
                    REG_CPR:       cpr_reg       <= cfg_wdata;
                    REG_RATIO_NUM: ratio_num_reg <= cfg_wdata;
                    REG_RATIO_DEN: ratio_den_reg <= cfg_wdata;
                    default:       invert_reg    <= invert_reg;
                endcase
            end

            chan_reg  <= chan_next;
            known_reg <= known_next;
            skip_reg  <= skip_next;
            pos_reg   <= start_meas ? '0 : pos_next;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (start_meas)
                    begin
                        last_ms_reg   <= now_ms;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_FREQ;
                    end
                end
                ST_MUL_FREQ:
                begin
                    if (mul_stat.done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_FREQ;
                    end
                end
                ST_DIV_FREQ:
                begin
                    if (div_stat.done)
                    begin
                        freq_reg      <= sat_s32(neg_reg, q_big, div_q[OUT_W-2:0]);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_RPMN;
                    end
                end
                ST_MUL_RPMN:
                begin
                    if (mul_stat.done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_RPMD;
                    end
                end
                ST_MUL_RPMD:
                begin
                    if (mul_stat.done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_RPM;
                    end
                end
                ST_DIV_RPM:
                begin
                    if (div_stat.done)
                    begin
                        if (nnum_reg == '0)
                        begin
                            rpm_reg <= '0;
                        end
                        else if (den_zero)
                        begin
                            rpm_reg <= sat_s32(neg_reg, 1'b1, '0);
                        end
                        else
                        begin
                            rpm_reg <= sat_s32(neg_reg, q_big, div_q[OUT_W-2:0]);
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (finish_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working operands and the output beat.
    always_ff @(posedge clk)
    begin
        if (start_meas)
        begin
            mag_reg <= snap_mag;
            neg_reg <= snap_neg;
            dt_reg  <= dt_now;
        end
        if (state_reg == ST_MUL_FREQ)
        begin
            t_reg <= TDT_W'(dt_reg) * TDT_W'(cpr_reg);
            k_reg <= OUT_W'(RPM_SCALE) * OUT_W'(ratio_num_reg);
        end
        if ((state_reg == ST_MUL_RPMN) && mul_stat.done)
        begin
            nnum_reg <= mul_product[NUM_W-1:0];
        end
        if (load_out)
        begin
            position_count_reg    <= pos_wide[OUT_W-1:0];
            skipped_total_reg     <= skip_next;
            channel_bits_reg      <= chan_next;
            counts_per_second_reg <= freq_reg;
            shaft_rpm_reg         <= rpm_reg;
            measured_reg          <= finish_load;
        end
    end

    assign out_valid         = out_valid_reg;
    assign position_count    = position_count_reg;
    assign skipped_total     = skipped_total_reg;
    assign channel_bits      = channel_bits_reg;
    assign counts_per_second = counts_per_second_reg;
    assign shaft_rpm         = shaft_rpm_reg;
    assign measured          = measured_reg;

    // No beat is taken while a measurement is in progress.
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input accepted while a measurement runs");

    // A measurement clears the count, so its beat shows a zero position.
    a_measure_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && measured) |-> (position_count == '0))
        else $error("measurement beat with nonzero position");

    // The two shared units never run at the same time.
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    // The divider finishes only in a divide step of the sequencer.
    a_div_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ((state_reg == ST_DIV_FREQ) || (state_reg == ST_DIV_RPM)))
        else $error("divider finished outside a divide step");

endmodule

[hw/rtl/qdr_mul.sv]
module qdr_mul
    import qdr_pkg::*;
#(
    parameter int A_W = 48,
    parameter int B_W = MUL_B_W
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] product,
    output unit_stat_t         stat
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   a_sh_reg;
    logic [B_W-1:0]   b_sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Step control: one multiplier bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-add datapath; the accumulator holds the product until the next start.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= P_W'(a);
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= {a_sh_reg[P_W-2:0], 1'b0};
            b_sh_reg <= {1'b0, b_sh_reg[B_W-1:1]};
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hw/rtl/qdr_div.sv]
module qdr_div
    import qdr_pkg::*;
#(
    parameter int N_W = 64,
    parameter int D_W = DIV_DEN_W
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [N_W-1:0] quotient,
    output unit_stat_t     stat
);

    localparam int CNT_W = $clog2(N_W);

    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [N_W-1:0]   q_sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    // One restoring step: bring down the next numerator bit and try to subtract.
    always_comb
    begin
        trial = {rem_reg, q_sh_reg[N_W-1]};
        ge    = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    // Step control: one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Numerator shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            den_reg  <= den;
            q_sh_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            q_sh_reg <= {q_sh_reg[N_W-2:0], ge};
        end
    end

    assign quotient  = q_sh_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[verif/quadrature_decoder_rpm_top_tb.sv]
module quadrature_decoder_rpm_top_tb
    import qdr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MS_IN_SEC = 1000;
    localparam int unsigned MS_IN_MIN = 60000;
    localparam int unsigned MAX_REPORTS = 10;

    // One input beat as the sender presents it.
    typedef struct packed {
        logic        op;
        logic        a;
        logic        b;
        logic [31:0] now;
    } beat_t;

    // One result beat, all fields as raw bits.
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] skipped;
        logic [1:0]  chans;
        logic [31:0] cps;
        logic [31:0] rpm;
        logic        did;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_INVERT;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_SAMPLE;
    logic        chan_a = 1'b0;
    logic        chan_b = 1'b0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [31:0] position_count;
    logic [31:0] skipped_total;
    logic [1:0]  channel_bits;
    logic signed [31:0] counts_per_second;
    logic signed [31:0] shaft_rpm;
    logic        measured;

    // Decoder state as the checker tracks it.
    logic [1:0]  enc_state = GRAY_00;
    logic        enc_known = 1'b0;
    logic [31:0] pos_acc = '0;
    logic [31:0] skip_acc = '0;
    logic [31:0] last_ms = '0;
    logic [31:0] cps_reg = '0;
    logic [31:0] rpm_reg = '0;

    // Register copies, at their reset values.
    logic        cfg_invert = 1'b0;
    logic [15:0] cfg_cpr = 16'd1;
    logic [15:0] cfg_num = 16'd1;
    logic [15:0] cfg_den = 16'd1;

    beat_t       beats_to_send [$];
    reading_t    readings_due [$];
    beat_t       on_wire;
    reading_t    oldest_reading;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit          free_run = 1'b0;

    // Stimulus generator state.
    logic [1:0]  gen_chan = GRAY_00;
    logic        gen_up = 1'b1;
    logic [31:0] gen_time = '0;

    int unsigned fail_count = 0;
    int unsigned readings_checked = 0;
    int unsigned rate_updates = 0;
    int unsigned rpm_clipped = 0;
    int unsigned settings_used = 1;

    quadrature_decoder_rpm_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .chan_a            (chan_a),
        .chan_b            (chan_b),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .position_count    (position_count),
        .skipped_total     (skipped_total),
        .channel_bits      (channel_bits),
        .counts_per_second (counts_per_second),
        .shaft_rpm         (shaft_rpm),
        .measured          (measured)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Neighbor of a channel code in the counting-up or counting-down direction.
    function automatic logic [1:0] next_code(input logic [1:0] code, input logic up);
        logic [1:0] fwd;
        logic [1:0] back;
        case (code)
            GRAY_00:
            begin
                fwd = GRAY_10;
                back = GRAY_01;
            end
            GRAY_10:
            begin
                fwd = GRAY_11;
                back = GRAY_00;
            end
            GRAY_11:
            begin
                fwd = GRAY_01;
                back = GRAY_10;
            end
            default:
            begin
                fwd = GRAY_00;
                back = GRAY_11;
            end
        endcase
        return up ? fwd : back;
    endfunction

    // Signed 32-bit value of a sign and a wide magnitude, clipped to range.
    function automatic logic [31:0] clip_signed(input logic neg, input logic [127:0] mag);
        if (neg)
        begin
            return (mag >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        end
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Advance the decoder state by one beat and return the reading it shows.
    function automatic reading_t decode_beat(input beat_t b);
        reading_t     res;
        logic [1:0]   code;
        logic [31:0]  snap;
        logic [31:0]  mag;
        logic [127:0] dt;
        logic [127:0] mag_w;
        logic [127:0] numer;
        logic [127:0] denom;
        logic         neg;
        logic         did;
        did = 1'b0;
        if (b.op == OP_SAMPLE)
        begin
            code = {b.a, b.b};
            if (!enc_known)
            begin
                // The first sample after reset only sets the starting code.
                enc_state = code;
                enc_known = 1'b1;
            end
            else if (code != enc_state)
            begin
                if (code == next_code(enc_state, 1'b1))
                    pos_acc = pos_acc + 32'd1;
                else if (code == next_code(enc_state, 1'b0))
                    pos_acc = pos_acc - 32'd1;
                else
                    skip_acc = skip_acc + 32'd1;
                enc_state = code;
            end
        end
        else if (b.now > last_ms)
        begin
            // Take the snapshot and compute both rates exactly before clipping.
            did = 1'b1;
            dt = 128'(b.now - last_ms);
            snap = cfg_invert ? -pos_acc : pos_acc;
            pos_acc = '0;
            neg = snap[31];
            mag = neg ? -snap : snap;
            mag_w = 128'(mag);
            numer = mag_w * 128'(MS_IN_MIN) * 128'(cfg_num);
            denom = dt * 128'(cfg_cpr) * 128'(cfg_den);
            cps_reg = clip_signed(neg, mag_w * 128'(MS_IN_SEC) / dt);
            if (numer == 0)
                rpm_reg = '0;
            else if (denom == 0)
                rpm_reg = clip_signed(neg, 128'(1) << 40);
            else
                rpm_reg = clip_signed(neg, numer / denom);
            if (rpm_reg == 32'h7FFF_FFFF || rpm_reg == 32'h8000_0000)
                rpm_clipped++;
            rate_updates++;
            last_ms = b.now;
        end
        res.position = pos_acc;
        res.skipped = skip_acc;
        res.chans = enc_state;
        res.cps = cps_reg;
        res.rpm = rpm_reg;
        res.did = did;
        return res;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (free_run || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic void compare_field(input string fname, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("result %0d: %s expected %h, got %h", readings_checked, fname,
                         want, got);
        end
    endfunction

    // Sender: presents queued beats and predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                readings_due.push_back(decode_beat(on_wire));
            if (!in_valid || !in_stall)
            begin
                if (send_gap == 0 && beats_to_send.size() != 0)
                begin
                    on_wire = beats_to_send.pop_front();
                    op <= on_wire.op;
                    chan_a <= on_wire.a;
                    chan_b <= on_wire.b;
                    now_ms <= on_wire.now;
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    if (send_gap != 0)
                        send_gap--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks every accepted result beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t ns: result beat arrived with none expected", $time);
                end
                else
                begin
                    oldest_reading = readings_due.pop_front();
                    compare_field("position_count", oldest_reading.position, position_count);
                    compare_field("skipped_total", oldest_reading.skipped, skipped_total);
                    compare_field("channel_bits", oldest_reading.chans, channel_bits);
                    compare_field("counts_per_second", oldest_reading.cps, counts_per_second);
                    compare_field("shaft_rpm", oldest_reading.rpm, shaft_rpm);
                    compare_field("measured", oldest_reading.did, measured);
                    readings_checked++;
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    task automatic queue_beat(input logic bop, input logic a, input logic b,
                              input logic [31:0] t);
        beat_t bt;
        bt.op = bop;
        bt.a = a;
        bt.b = b;
        bt.now = t;
        beats_to_send.push_back(bt);
    endtask

    // Wait until nothing is queued, on the wire, or owed by the block.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (beats_to_send.size() != 0 || in_valid || readings_due.size() != 0);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_INVERT:    cfg_invert = val[0];
            REG_CPR:       cfg_cpr = val;
            REG_RATIO_NUM: cfg_num = val;
            default:       cfg_den = val;
        endcase
    endtask

    // Load all four registers while the block is idle.
    task automatic set_config(input logic inv, input logic [15:0] cpr, input logic [15:0] num,
                              input logic [15:0] den);
        wait_idle();
        write_reg(REG_INVERT, {15'($urandom), inv});
        write_reg(REG_CPR, cpr);
        write_reg(REG_RATIO_NUM, num);
        write_reg(REG_RATIO_DEN, den);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly clean Gray runs with occasional reversals, repeats, jumps and measurements.
    task automatic run_phase(input int unsigned count);
        int unsigned i;
        int unsigned r;
        int unsigned k;
        for (i = 0; i < count; i++)
        begin
            // Drain between chunks; some chunks run with no idling at all.
            if (i % 50 == 0)
            begin
                wait_idle();
                free_run = ($urandom_range(3, 0) == 0);
            end
            r = $urandom_range(99, 0);
            if (r < 8)
            begin
                k = $urandom_range(99, 0);
                if (k < 50)
                    gen_time = gen_time + $urandom_range(20, 1);
                else if (k < 80)
                    gen_time = gen_time + $urandom_range(2000, 21);
                else if (k < 95)
                    gen_time = gen_time + $urandom_range(100000, 2001);
                else
                    gen_time = gen_time + $urandom_range(1 << 22, 100001);
                queue_beat(OP_MEASURE, 1'($urandom), 1'($urandom), gen_time);
            end
            else if (r < 10)
            begin
                queue_beat(OP_MEASURE, 1'($urandom), 1'($urandom),
                           $urandom_range(gen_time, 0));
            end
            else
            begin
                if (r < 13)
                    gen_chan = gen_chan ^ 2'b11;
                else if (r >= 18)
                begin
                    if ($urandom_range(11, 0) == 0)
                        gen_up = !gen_up;
                    gen_chan = next_code(gen_chan, gen_up);
                end
                queue_beat(OP_SAMPLE, gen_chan[1], gen_chan[0], $urandom);
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Measurements before any sample, first-sample latch, legal steps both ways, jumps.
        queue_beat(OP_MEASURE, 1'b1, 1'b1, 32'd0);
        queue_beat(OP_MEASURE, 1'b0, 1'b0, 32'd7);
        queue_beat(OP_SAMPLE, 1'b1, 1'b1, 32'hFFFF_FFFF);
        queue_beat(OP_SAMPLE, 1'b1, 1'b1, 32'd0);
        queue_beat(OP_SAMPLE, 1'b0, 1'b1, 32'd0);
        queue_beat(OP_SAMPLE, 1'b0, 1'b0, 32'd0);
        queue_beat(OP_SAMPLE, 1'b1, 1'b0, 32'd0);
        queue_beat(OP_SAMPLE, 1'b1, 1'b1, 32'd0);
        queue_beat(OP_SAMPLE, 1'b1, 1'b0, 32'd0);
        queue_beat(OP_SAMPLE, 1'b0, 1'b0, 32'd0);
        queue_beat(OP_SAMPLE, 1'b1, 1'b1, 32'd0);
        queue_beat(OP_SAMPLE, 1'b0, 1'b0, 32'd0);
        queue_beat(OP_MEASURE, 1'b0, 1'b1, 32'd7);
        queue_beat(OP_MEASURE, 1'b1, 1'b0, 32'd8);
        queue_beat(OP_SAMPLE, 1'b0, 1'b1, 32'd0);
        queue_beat(OP_SAMPLE, 1'b1, 1'b0, 32'd0);
        queue_beat(OP_MEASURE, 1'b0, 1'b0, 32'd1008);
        gen_time = 32'd1008;
        gen_chan = GRAY_10;

        run_phase(200);
        set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(200);
        // Zero counts per revolution.
        set_config(1'b0, 16'd0, 16'hFFFF, 16'd1);
        run_phase(200);
        // Zero ratio denominator, inverted direction.
        set_config(1'b1, 16'd7, 16'd1, 16'd0);
        run_phase(200);
        // Push the time base past the top bit, with rpm mostly saturating.
        gen_time = gen_time + 32'h8000_0000;
        set_config(1'b0, 16'd1, 16'hFFFF, 16'd1);
        run_phase(200);
        set_config(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(200);
        set_config(1'b0, 16'hFFFF, 16'd1, 16'hFFFF);
        run_phase(200);

        // Time at its top value, then a wrapped and an equal stamp, then a last step.
        queue_beat(OP_MEASURE, 1'b1, 1'b0, 32'hFFFF_FFFF);
        queue_beat(OP_MEASURE, 1'b0, 1'b1, 32'd3);
        queue_beat(OP_MEASURE, 1'b1, 1'b1, 32'hFFFF_FFFF);
        queue_beat(OP_SAMPLE,
                   1'(next_code(gen_chan, 1'b1) >> 1),
                   1'(next_code(gen_chan, 1'b1)),
                   32'd0);

        wait_idle();
        repeat (300) @(posedge clk);
        $display("Checked %0d result beats over %0d register settings.", readings_checked,
                 settings_used);
        $display("Rate updates: %0d, clipped rpm readings: %0d, skipped steps: %0d.",
                 rate_updates, rpm_clipped, skip_acc);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
